@@ rtl/cau_pkg.sv @@
// Shared types and codes for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

    localparam int CAU_WORD_BITS = 32;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_NEG  = 3'd4;
    localparam logic [2:0] CMD_CONJ = 3'd5;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DIV0 = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    typedef struct packed {
        logic        [2:0]               command;
        logic signed [CAU_WORD_BITS-1:0] a_real;
        logic signed [CAU_WORD_BITS-1:0] a_imag;
        logic signed [CAU_WORD_BITS-1:0] b_real;
        logic signed [CAU_WORD_BITS-1:0] b_imag;
    } t_in_word;

    typedef struct packed {
        logic signed [CAU_WORD_BITS-1:0] out_real;
        logic signed [CAU_WORD_BITS-1:0] out_imag;
        logic        [1:0]               status;
    } t_out_word;

    // per-item flags that ride along the divider chain
    typedef struct packed {
        logic is_div;
        logic dz;
        logic re_neg;
        logic im_neg;
    } t_ctl;

endpackage

`default_nettype wire

@@ rtl/complex_arithmetic_unit.sv @@
// Complex ALU top level: front pipeline, divider chain, output stage.
//
// Input channel i_valid/o_ready carries one word: command and operands A, B
// (signed fixed point, FRAC_BITS fraction bits). Output channel
// o_valid/i_ready carries one result word: real and imaginary parts and status.
// Every command runs through the same pipeline, so results leave in order.
// Latency is 38 register stages: four front stages (operand register, products,
// sums, magnitude), 33 divider steps of one quotient bit each (top step is the
// overflow check), and the output register.
// Throughput is one word per cycle while the receiver holds i_ready high; the
// pipeline length is set by the bit-per-stage divider.
// Each stage holds its word until the next one frees up, so a stalled receiver
// fills the pipeline bubble by bubble; o_ready drops only when every stage is
// full. Nothing is dropped or repeated.
// Reset (synchronous, active low) empties all stages; only the valid flags are cleared.
`default_nettype none

module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire cau_pkg::t_in_word   i_word,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output cau_pkg::t_out_word       o_word
);

    localparam int W  = cau_pkg::CAU_WORD_BITS;
    localparam int RB = 2 * W + 3 + FRAC_BITS;
    localparam int DB = 2 * W + 1;
    localparam int NS = W + 1;

    logic          vld_c [NS+1];
    logic          rdy_c [NS+1];
    cau_pkg::t_ctl ctl_c [NS+1];
    logic [RB-1:0] re_c  [NS+1];
    logic [RB-1:0] im_c  [NS+1];
    logic [W:0]    req_c [NS+1];
    logic [W:0]    imq_c [NS+1];
    logic [DB-1:0] den_c [NS+1];

    assign req_c[0] = '0;
    assign imq_c[0] = '0;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (vld_c[0]),
        .i_ready (rdy_c[0]),
        .o_ctl   (ctl_c[0]),
        .o_re    (re_c[0]),
        .o_im    (im_c[0]),
        .o_den   (den_c[0])
    );

    for (genvar k = 0; k < NS; k++) begin : g_div
        cau_div_stage #(.FRAC_BITS(FRAC_BITS), .BIT(W - k)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld_c[k]),
            .o_ready (rdy_c[k]),
            .i_ctl   (ctl_c[k]),
            .i_re    (re_c[k]),
            .i_im    (im_c[k]),
            .i_re_q  (req_c[k]),
            .i_im_q  (imq_c[k]),
            .i_den   (den_c[k]),
            .o_valid (vld_c[k+1]),
            .i_ready (rdy_c[k+1]),
            .o_ctl   (ctl_c[k+1]),
            .o_re    (re_c[k+1]),
            .o_im    (im_c[k+1]),
            .o_re_q  (req_c[k+1]),
            .o_im_q  (imq_c[k+1]),
            .o_den   (den_c[k+1])
        );
    end

    cau_out #(.FRAC_BITS(FRAC_BITS)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld_c[NS]),
        .o_ready (rdy_c[NS]),
        .i_ctl   (ctl_c[NS]),
        .i_re    (re_c[NS]),
        .i_im    (im_c[NS]),
        .i_re_q  (req_c[NS]),
        .i_im_q  (imq_c[NS]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

endmodule

`default_nettype wire

@@ rtl/cau_front.sv @@
// Front pipeline: operand register, products, sums, magnitude prep.
`default_nettype none

module cau_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_valid,
    output logic                                               o_ready,
    input  wire cau_pkg::t_in_word                             i_word,
    output logic                                               o_valid,
    input  wire logic                                          i_ready,
    output cau_pkg::t_ctl                                      o_ctl,
    output logic [2*cau_pkg::CAU_WORD_BITS+3+FRAC_BITS-1:0]    o_re,
    output logic [2*cau_pkg::CAU_WORD_BITS+3+FRAC_BITS-1:0]    o_im,
    output logic [2*cau_pkg::CAU_WORD_BITS+1-1:0]              o_den
);

    localparam int W  = cau_pkg::CAU_WORD_BITS;
    localparam int W1 = W + 1;
    localparam int Q  = 2 * W;
    localparam int P  = 2 * W + 2;
    localparam int V  = 2 * W + 3;
    localparam int RB = V + FRAC_BITS;
    localparam int DB = 2 * W + 1;

    logic en1, en2, en3, en4;

    // stage 1: operands and Gauss pre-adds
    logic                 r_s1_valid;
    logic [2:0]           r_s1_cmd;
    logic signed [W-1:0]  r_s1_ar, r_s1_ai, r_s1_br, r_s1_bi;
    logic signed [W1-1:0] r_s1_sa, r_s1_sb;

    // stage 2: products
    logic                 r_s2_valid;
    logic [2:0]           r_s2_cmd;
    logic signed [W-1:0]  r_s2_ar, r_s2_ai, r_s2_br, r_s2_bi;
    logic signed [P-1:0]  r_s2_p1;
    logic signed [Q-1:0]  r_s2_p2, r_s2_p3, r_s2_p4, r_s2_p5, r_s2_p6;

    // stage 3: exact sums
    logic                 r_s3_valid;
    logic                 r_s3_div;
    logic signed [V-1:0]  r_s3_re, r_s3_im;
    logic [DB-1:0]        r_s3_den;

    // stage 4: magnitudes for the divider
    logic                 r_s4_valid;
    cau_pkg::t_ctl        r_s4_ctl;
    logic [RB-1:0]        r_s4_re, r_s4_im;
    logic [DB-1:0]        r_s4_den;

    logic signed [W1-1:0] n_s1_sa, n_s1_sb;
    logic signed [W1-1:0] op1a, op1b;
    logic signed [V-1:0]  e1, e2, e3, e4, e5, e6;
    logic signed [V-1:0]  ear, eai, ebr, ebi;
    logic signed [V-1:0]  mul_re, mul_im, den_sum;
    logic signed [V-1:0]  n_s3_re, n_s3_im;
    logic                 n_s3_div;
    logic [V-1:0]         mag_re, mag_im;
    cau_pkg::t_ctl        n_s4_ctl;
    logic [RB-1:0]        n_s4_re, n_s4_im;

    assign en4     = !r_s4_valid || i_ready;
    assign en3     = !r_s3_valid || en4;
    assign en2     = !r_s2_valid || en3;
    assign en1     = !r_s1_valid || en2;
    assign o_ready = en1;

    assign n_s1_sa = $signed({i_word.a_real[W-1], i_word.a_real})
                   + $signed({i_word.a_imag[W-1], i_word.a_imag});
    assign n_s1_sb = $signed({i_word.b_real[W-1], i_word.b_real})
                   - $signed({i_word.b_imag[W-1], i_word.b_imag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= i_valid;
        end
        if (en1 && i_valid) begin
            r_s1_cmd <= i_word.command;
            r_s1_ar  <= i_word.a_real;
            r_s1_ai  <= i_word.a_imag;
            r_s1_br  <= i_word.b_real;
            r_s1_bi  <= i_word.b_imag;
            r_s1_sa  <= n_s1_sa;
            r_s1_sb  <= n_s1_sb;
        end
    end

    // first multiplier is shared: (ar+ai)(br-bi) for multiply, ar*br otherwise
    assign op1a = (r_s1_cmd == cau_pkg::CMD_MUL) ? r_s1_sa : $signed({r_s1_ar[W-1], r_s1_ar});
    assign op1b = (r_s1_cmd == cau_pkg::CMD_MUL) ? r_s1_sb : $signed({r_s1_br[W-1], r_s1_br});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
        if (en2 && r_s1_valid) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_ar  <= r_s1_ar;
            r_s2_ai  <= r_s1_ai;
            r_s2_br  <= r_s1_br;
            r_s2_bi  <= r_s1_bi;
            r_s2_p1  <= op1a * op1b;
            r_s2_p2  <= r_s1_ai * r_s1_bi;
            r_s2_p3  <= r_s1_ai * r_s1_br;
            r_s2_p4  <= r_s1_ar * r_s1_bi;
            r_s2_p5  <= r_s1_br * r_s1_br;
            r_s2_p6  <= r_s1_bi * r_s1_bi;
        end
    end

    assign e1  = {r_s2_p1[P-1], r_s2_p1};
    assign e2  = {{(V-Q){r_s2_p2[Q-1]}}, r_s2_p2};
    assign e3  = {{(V-Q){r_s2_p3[Q-1]}}, r_s2_p3};
    assign e4  = {{(V-Q){r_s2_p4[Q-1]}}, r_s2_p4};
    assign e5  = {{(V-Q){r_s2_p5[Q-1]}}, r_s2_p5};
    assign e6  = {{(V-Q){r_s2_p6[Q-1]}}, r_s2_p6};
    assign ear = {{(V-W){r_s2_ar[W-1]}}, r_s2_ar};
    assign eai = {{(V-W){r_s2_ai[W-1]}}, r_s2_ai};
    assign ebr = {{(V-W){r_s2_br[W-1]}}, r_s2_br};
    assign ebi = {{(V-W){r_s2_bi[W-1]}}, r_s2_bi};

    assign mul_re  = (e1 - e3 + e4) >>> FRAC_BITS;
    assign mul_im  = (e3 + e4) >>> FRAC_BITS;
    assign den_sum = e5 + e6;

    always_comb begin
        n_s3_re  = '0;
        n_s3_im  = '0;
        n_s3_div = 1'b0;
        unique case (r_s2_cmd)
            cau_pkg::CMD_ADD: begin
                n_s3_re = ear + ebr;
                n_s3_im = eai + ebi;
            end
            cau_pkg::CMD_SUB: begin
                n_s3_re = ear - ebr;
                n_s3_im = eai - ebi;
            end
            cau_pkg::CMD_MUL: begin
                n_s3_re = mul_re;
                n_s3_im = mul_im;
            end
            cau_pkg::CMD_DIV: begin
                // numerator A * conj(B)
                n_s3_re  = e1 + e2;
                n_s3_im  = e3 - e4;
                n_s3_div = 1'b1;
            end
            cau_pkg::CMD_NEG: begin
                n_s3_re = -ear;
                n_s3_im = -eai;
            end
            cau_pkg::CMD_CONJ: begin
                n_s3_re = ear;
                n_s3_im = -eai;
            end
            default: begin
                n_s3_re = '0;
                n_s3_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en3) begin
            r_s3_valid <= r_s2_valid;
        end
        if (en3 && r_s2_valid) begin
            r_s3_div <= n_s3_div;
            r_s3_re  <= n_s3_re;
            r_s3_im  <= n_s3_im;
            r_s3_den <= den_sum[DB-1:0];
        end
    end

    assign mag_re = r_s3_re[V-1] ? -r_s3_re : r_s3_re;
    assign mag_im = r_s3_im[V-1] ? -r_s3_im : r_s3_im;

    always_comb begin
        n_s4_ctl.is_div = r_s3_div;
        n_s4_ctl.dz     = (r_s3_den == '0);
        n_s4_ctl.re_neg = r_s3_re[V-1];
        n_s4_ctl.im_neg = r_s3_im[V-1];
        if (r_s3_div) begin
            n_s4_re = RB'(mag_re) << FRAC_BITS;
            n_s4_im = RB'(mag_im) << FRAC_BITS;
        end else begin
            n_s4_re = RB'(r_s3_re);
            n_s4_im = RB'(r_s3_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (en4) begin
            r_s4_valid <= r_s3_valid;
        end
        if (en4 && r_s3_valid) begin
            r_s4_ctl <= n_s4_ctl;
            r_s4_re  <= n_s4_re;
            r_s4_im  <= n_s4_im;
            r_s4_den <= r_s3_den;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_ctl   = r_s4_ctl;
    assign o_re    = r_s4_re;
    assign o_im    = r_s4_im;
    assign o_den   = r_s4_den;

endmodule

`default_nettype wire

@@ rtl/cau_div_stage.sv @@
// One restoring-division step: one quotient bit for both lanes.
`default_nettype none

module cau_div_stage #(
    parameter int FRAC_BITS = 16,
    parameter int BIT       = 0
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_valid,
    output logic                                               o_ready,
    input  wire cau_pkg::t_ctl                                 i_ctl,
    input  wire logic [2*cau_pkg::CAU_WORD_BITS+3+FRAC_BITS-1:0] i_re,
    input  wire logic [2*cau_pkg::CAU_WORD_BITS+3+FRAC_BITS-1:0] i_im,
    input  wire logic [cau_pkg::CAU_WORD_BITS:0]               i_re_q,
    input  wire logic [cau_pkg::CAU_WORD_BITS:0]               i_im_q,
    input  wire logic [2*cau_pkg::CAU_WORD_BITS+1-1:0]         i_den,
    output logic                                               o_valid,
    input  wire logic                                          i_ready,
    output cau_pkg::t_ctl                                      o_ctl,
    output logic [2*cau_pkg::CAU_WORD_BITS+3+FRAC_BITS-1:0]    o_re,
    output logic [2*cau_pkg::CAU_WORD_BITS+3+FRAC_BITS-1:0]    o_im,
    output logic [cau_pkg::CAU_WORD_BITS:0]                    o_re_q,
    output logic [cau_pkg::CAU_WORD_BITS:0]                    o_im_q,
    output logic [2*cau_pkg::CAU_WORD_BITS+1-1:0]              o_den
);

    localparam int W  = cau_pkg::CAU_WORD_BITS;
    localparam int RB = 2 * W + 3 + FRAC_BITS;
    localparam int DB = 2 * W + 1;
    localparam int CW = RB + W + 1;

    logic                r_valid;
    cau_pkg::t_ctl       r_ctl;
    logic [RB-1:0]       r_re, r_im;
    logic [W:0]          r_re_q, r_im_q;
    logic [DB-1:0]       r_den;

    logic                en;
    logic [CW-1:0]       den_sh, re_x, im_x, re_dif, im_dif;
    logic                ge_re, ge_im;
    logic [RB-1:0]       n_re, n_im;
    logic [W:0]          n_re_q, n_im_q;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    assign den_sh = CW'(i_den) << BIT;
    assign re_x   = CW'(i_re);
    assign im_x   = CW'(i_im);
    assign re_dif = re_x - den_sh;
    assign im_dif = im_x - den_sh;
    assign ge_re  = i_ctl.is_div && (re_x >= den_sh);
    assign ge_im  = i_ctl.is_div && (im_x >= den_sh);

    // at the top step the bit set here marks a quotient too large for a word
    always_comb begin
        n_re        = ge_re ? re_dif[RB-1:0] : i_re;
        n_im        = ge_im ? im_dif[RB-1:0] : i_im;
        n_re_q      = i_re_q;
        n_im_q      = i_im_q;
        n_re_q[BIT] = ge_re;
        n_im_q[BIT] = ge_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
        if (en && i_valid) begin
            r_ctl  <= i_ctl;
            r_re   <= n_re;
            r_im   <= n_im;
            r_re_q <= n_re_q;
            r_im_q <= n_im_q;
            r_den  <= i_den;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_re    = r_re;
    assign o_im    = r_im;
    assign o_re_q  = r_re_q;
    assign o_im_q  = r_im_q;
    assign o_den   = r_den;

endmodule

`default_nettype wire

@@ rtl/cau_out.sv @@
// Output stage: sign, saturation, status and the result register.
`default_nettype none

module cau_out #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_valid,
    output logic                                               o_ready,
    input  wire cau_pkg::t_ctl                                 i_ctl,
    input  wire logic [2*cau_pkg::CAU_WORD_BITS+3+FRAC_BITS-1:0] i_re,
    input  wire logic [2*cau_pkg::CAU_WORD_BITS+3+FRAC_BITS-1:0] i_im,
    input  wire logic [cau_pkg::CAU_WORD_BITS:0]               i_re_q,
    input  wire logic [cau_pkg::CAU_WORD_BITS:0]               i_im_q,
    output logic                                               o_valid,
    input  wire logic                                          i_ready,
    output cau_pkg::t_out_word                                 o_word
);

    localparam int W = cau_pkg::CAU_WORD_BITS;
    localparam int V = 2 * W + 3;
    localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic         sat;
        logic [W-1:0] val;
    } t_lane;

    function automatic t_lane sat_lane(input logic is_div, input logic neg,
                                       input logic [V-1:0] v, input logic [W:0] q);
        t_lane        r;
        logic [V-W:0] hi;
        hi = v[V-1:W-1];
        r.sat = 1'b0;
        r.val = v[W-1:0];
        if (!is_div) begin
            if (!((&hi) || !(|hi))) begin
                r.sat = 1'b1;
                r.val = v[V-1] ? MIN_W : MAX_W;
            end
        end else if (q[W]) begin
            r.sat = 1'b1;
            r.val = neg ? MIN_W : MAX_W;
        end else if (neg) begin
            if (q[W-1:0] > MIN_W) begin
                r.sat = 1'b1;
                r.val = MIN_W;
            end else begin
                r.val = -q[W-1:0];
            end
        end else begin
            if (q[W-1]) begin
                r.sat = 1'b1;
                r.val = MAX_W;
            end else begin
                r.val = q[W-1:0];
            end
        end
        return r;
    endfunction

    logic               r_valid;
    cau_pkg::t_out_word r_word;
    logic               en;
    t_lane              lane_re, lane_im;
    cau_pkg::t_out_word n_word;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    assign lane_re = sat_lane(i_ctl.is_div, i_ctl.re_neg, i_re[V-1:0], i_re_q);
    assign lane_im = sat_lane(i_ctl.is_div, i_ctl.im_neg, i_im[V-1:0], i_im_q);

    always_comb begin
        if (i_ctl.is_div && i_ctl.dz) begin
            n_word.out_real = '0;
            n_word.out_imag = '0;
            n_word.status   = cau_pkg::STAT_DIV0;
        end else begin
            n_word.out_real = lane_re.val;
            n_word.out_imag = lane_im.val;
            n_word.status   = (lane_re.sat || lane_im.sat) ? cau_pkg::STAT_SAT
                                                           : cau_pkg::STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
        if (en && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for the complex arithmetic unit: random and directed words, in-order result checks.
`default_nettype none

module testbench;

    localparam int FRAC      = 16;
    localparam int LATENCY   = 38;
    localparam int WD_LIMIT  = 4000;
    localparam int N_RANDOM  = 1300;

    logic               clk;
    logic               rst_n;
    logic               in_valid = 1'b0;
    logic               in_ready;
    cau_pkg::t_in_word  in_word = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    cau_pkg::t_out_word out_word;

    complex_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_word(in_word),
        .o_valid(out_valid), .i_ready(out_ready), .o_word(out_word)
    );

    always begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    cau_pkg::t_in_word  pending_words[$];
    cau_pkg::t_out_word expected_results[$];
    int        mismatches = 0;
    bit        stim_done = 0;
    bit        hold_rx = 0;          // long receiver hold-off
    int        pause_marks[$];       // sender waits for drain before these items
    int        sent_count = 0;

    // exact-width arithmetic, wide enough for shifted products
    typedef logic signed [159:0] t_wide;

    function automatic logic [32:0] saturate(input t_wide v);
        // bit 32 set means the value was clipped
        if (v > t_wide'(32'sh7fffffff))
            return {1'b1, 32'h7fffffff};
        if (v < -t_wide'(64'sh80000000))
            return {1'b1, 32'h80000000};
        return {1'b0, v[31:0]};
    endfunction

    function automatic t_wide div_trunc(input t_wide n, input t_wide d);
        t_wide an, ad, q;
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        q = an / ad;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic cau_pkg::t_out_word complex_result(input cau_pkg::t_in_word w);
        t_wide ar, ai, br, bi, re, im, m1, m2, m3, den;
        logic [32:0] sr, si;
        cau_pkg::t_out_word r;
        logic [1:0] st;
        ar = w.a_real; ai = w.a_imag; br = w.b_real; bi = w.b_imag;
        re = 0; im = 0; st = cau_pkg::STAT_OK;
        case (w.command)
            cau_pkg::CMD_ADD: begin re = ar + br; im = ai + bi; end
            cau_pkg::CMD_SUB: begin re = ar - br; im = ai - bi; end
            cau_pkg::CMD_MUL: begin
                m1 = (ar + ai) * (br - bi);
                m2 = ai * br;
                m3 = ar * bi;
                re = (m1 - m2 + m3) >>> FRAC;
                im = (m2 + m3) >>> FRAC;
            end
            cau_pkg::CMD_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) st = cau_pkg::STAT_DIV0;
                else begin
                    re = div_trunc((ar * br + ai * bi) <<< FRAC, den);
                    im = div_trunc((ai * br - ar * bi) <<< FRAC, den);
                end
            end
            cau_pkg::CMD_NEG:  begin re = -ar; im = -ai; end
            cau_pkg::CMD_CONJ: begin re = ar;  im = -ai; end
            default: ;
        endcase
        sr = saturate(re);
        si = saturate(im);
        if ((sr[32] || si[32]) && st == cau_pkg::STAT_OK) st = cau_pkg::STAT_SAT;
        r.out_real = sr[31:0];
        r.out_imag = si[31:0];
        r.status = st;
        return r;
    endfunction

    function automatic logic [31:0] rand_part(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'h80000000;
            2: return 32'h7fffffff;
            3: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
            4: return 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return 32'd0;
        endcase
    endfunction

    function automatic cau_pkg::t_in_word make_word(input logic [2:0] c,
                                                    input logic [31:0] a0,
                                                    input logic [31:0] a1,
                                                    input logic [31:0] b0,
                                                    input logic [31:0] b1);
        cau_pkg::t_in_word w;
        w.command = c; w.a_real = a0; w.a_imag = a1; w.b_real = b0; w.b_imag = b1;
        return w;
    endfunction

    task automatic report(input string what, input cau_pkg::t_out_word got,
                          input cau_pkg::t_out_word want);
        $display("mismatch %s: got %h %h %0d want %h %h %0d", what, got.out_real,
                 got.out_imag, got.status, want.out_real, want.out_imag, want.status);
        mismatches++;
    endtask

    initial begin
        logic [31:0] mx, mn, one;
        logic [2:0] c;
        mx = 32'h7fffffff; mn = 32'h80000000; one = 32'h00010000;
        // directed words
        for (int k = 0; k < 8; k++) begin
            c = k[2:0];
            pending_words.push_back(make_word(c, mx, mn, mx, mn));
            pending_words.push_back(make_word(c, one, 32'hffff0000, 32'h00020000, one));
        end
        pending_words.push_back(make_word(cau_pkg::CMD_DIV, one, one, 0, 0));
        pending_words.push_back(make_word(cau_pkg::CMD_DIV, one, 0, 32'h00030000,
                                          32'h00040000));
        pending_words.push_back(make_word(cau_pkg::CMD_DIV, mx, mx, 1, 0));
        pending_words.push_back(make_word(cau_pkg::CMD_NEG, mn, 0, 0, 0));
        pending_words.push_back(make_word(cau_pkg::CMD_CONJ, 0, mn, 0, 0));
        pending_words.push_back(make_word(cau_pkg::CMD_MUL, mn, mn, mn, mn));
        pending_words.push_back(make_word(cau_pkg::CMD_ADD, 32'hffffffff, 0,
                                          32'hffffffff, 0));
        for (int n = 0; n < N_RANDOM; n++) begin
            int kind;
            kind = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
            pending_words.push_back(make_word(3'($urandom_range(0, 7)),
                rand_part(kind), rand_part($urandom_range(0, 4) == 0 ? 5 : kind),
                rand_part(kind), rand_part($urandom_range(0, 9) == 0 ? 5 : kind)));
        end
        pause_marks.push_back(400);
        pause_marks.push_back(900);
    end

    // driver, with the prediction taken on each accepted word
    int tx_wait = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end else begin
            if (in_valid && in_ready) begin
                sent_count++;
                expected_results.push_back(complex_result(in_word));
            end
            if (!(in_valid && !in_ready)) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end else if (pause_marks.size() > 0 && sent_count == pause_marks[0]
                             && expected_results.size() != 0) begin
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    if (pause_marks.size() > 0 && sent_count == pause_marks[0])
                        void'(pause_marks.pop_front());
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    tx_wait  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
                end else begin
                    in_valid <= 1'b0;
                    stim_done = 1;
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps going
    initial begin
        wait (sent_count >= 150);
        @(posedge clk);
        hold_rx = 1;
        repeat (200) @(posedge clk);
        hold_rx = 0;
    end

    // monitor
    int rx_wait = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected", out_word, '0);
                end else begin
                    cau_pkg::t_out_word want;
                    want = expected_results.pop_front();
                    if (out_word.out_real !== want.out_real) report("real", out_word, want);
                    if (out_word.out_imag !== want.out_imag) report("imag", out_word, want);
                    if (out_word.status !== want.status) report("status", out_word, want);
                end
                rx_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
            end
            if (hold_rx) out_ready <= 1'b0;
            else if (rx_wait > 0) begin
                rx_wait--;
                out_ready <= 1'b0;
            end else out_ready <= 1'b1;
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("FAIL complex_arithmetic_unit");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && expected_results.size() == 0);
        repeat (LATENCY * 2) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS complex_arithmetic_unit");
        else
            $display("FAIL complex_arithmetic_unit");
        $finish;
    end
endmodule

`default_nettype wire
